[design/equirect_to_cubemap_addr_assert.svh]
// assertion macros shared by the address generator
`ifndef EQUIRECT_TO_CUBEMAP_ADDR_ASSERT_SVH
`define EQUIRECT_TO_CUBEMAP_ADDR_ASSERT_SVH

// antecedent in the same cycle implies consequent
`define E2C_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define E2C_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/e2c_pkg.sv]
`timescale 1ns / 1ps
package e2c_pkg;

    localparam int CFG_W = 14;
    localparam logic [CFG_W-1:0] SRC_W_RESET = 14'd2048;
    localparam logic [CFG_W-1:0] SRC_W_MIN = 14'd4;

    // angles in units of 2^-32 turn, with headroom for the half-turn start
    localparam int ANG_W = 34;
    localparam int ANG_FRAC = 32;
    localparam logic signed [ANG_W-1:0] ANG_HALF = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 34'sd1073741824;

    localparam int TAB_LEN = 28;
    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic [2:0]  face;
        logic [10:0] pix_x;
        logic [10:0] pix_y;
    } t_item;

    typedef struct packed {
        logic [12:0] src_col;
        logic [11:0] src_row;
        logic [24:0] src_index;
        logic        face_bad;
    } t_res;

    typedef struct packed {
        logic [2:0]  face;
        logic [10:0] px;
        logic [10:0] py;
        logic        bad;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

[design/e2c_front.sv]
`timescale 1ns / 1ps
module e2c_front import e2c_pkg::*; (
    input  logic        i_start,
    input  t_item       i_item,
    input  logic [11:0] i_face_size,
    input  logic        i_full,
    output logic        o_busy,
    output t_push       o_push
);

    logic [11:0] lim;

    assign lim = i_face_size - 12'd1;
    assign o_busy = i_full;

    always_comb begin
        o_push.push = i_start && !i_full;
        o_push.entry.face = i_item.face;
        o_push.entry.bad = i_item.face > FACE_NEG_Z;
        // pixels past the face edge saturate to the last pixel
        o_push.entry.px = ({1'b0, i_item.pix_x} > lim) ? lim[10:0] : i_item.pix_x;
        o_push.entry.py = ({1'b0, i_item.pix_y} > lim) ? lim[10:0] : i_item.pix_y;
    end

endmodule

[design/e2c_queue.sv]
`timescale 1ns / 1ps
module e2c_queue import e2c_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic            wr_en, rd_en;

    assign o_full  = r_cnt == NW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];
    assign wr_en   = i_push.push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + NW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
        if (wr_en) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

endmodule

[design/e2c_cordic.sv]
`timescale 1ns / 1ps
module e2c_cordic import e2c_pkg::*; #(
    parameter int CW = 20,
    parameter int STAGES = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [CW-1:0]    i_x,
    input  logic signed [CW-1:0]    i_y,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_ang
);

    logic                    r_p_vld, r_p_zero;
    logic signed [CW-1:0]    r_p_x, r_p_y;
    logic signed [ANG_W-1:0] r_p_z;

    logic                    r_c_vld  [STAGES];
    logic                    r_c_zero [STAGES];
    logic signed [CW-1:0]    r_c_x    [STAGES];
    logic signed [CW-1:0]    r_c_y    [STAGES];
    logic signed [ANG_W-1:0] r_c_z    [STAGES];

    // left half plane: rotate by half a turn first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_valid;
        end
        r_p_zero <= (i_x == '0) && (i_y == '0);
        if (i_x[CW-1]) begin
            r_p_x <= -i_x;
            r_p_y <= -i_y;
            r_p_z <= i_y[CW-1] ? -ANG_HALF : ANG_HALF;
        end else begin
            r_p_x <= i_x;
            r_p_y <= i_y;
            r_p_z <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                    vld_in, zero_in, y_pos;
        logic signed [CW-1:0]    x_in, y_in, xs, ys;
        logic signed [ANG_W-1:0] z_in, ang;

        if (i == 0) begin : g_first
            assign vld_in = r_p_vld;
            assign zero_in = r_p_zero;
            assign x_in = r_p_x;
            assign y_in = r_p_y;
            assign z_in = r_p_z;
        end else begin : g_next
            assign vld_in = r_c_vld[i-1];
            assign zero_in = r_c_zero[i-1];
            assign x_in = r_c_x[i-1];
            assign y_in = r_c_y[i-1];
            assign z_in = r_c_z[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;
        assign y_pos = !y_in[CW-1] && (y_in != '0);
        assign ang = $signed({2'b00, ATAN_TAB[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[i] <= 1'b0;
            end else begin
                r_c_vld[i] <= vld_in;
            end
            r_c_zero[i] <= zero_in;
            if (y_pos) begin
                r_c_x[i] <= x_in + ys;
                r_c_y[i] <= y_in - xs;
                r_c_z[i] <= z_in + ang;
            end else begin
                r_c_x[i] <= x_in - ys;
                r_c_y[i] <= y_in + xs;
                r_c_z[i] <= z_in - ang;
            end
        end
    end

    assign o_valid = r_c_vld[STAGES-1];
    assign o_ang = r_c_zero[STAGES-1] ? '0 : r_c_z[STAGES-1];

endmodule

[design/e2c_back.sv]
`timescale 1ns / 1ps
module e2c_back import e2c_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_entry           i_entry,
    input  logic [CFG_W-1:0] i_w,
    output logic             o_strobe,
    output t_res             o_res
);

    localparam int FB = FRAC_BITS;
    localparam int DW = FB + 2;          // signed Q2.FB direction component
    localparam int QB = FB + 1;          // quotient bits of the centre mapping
    localparam int NB = FB + 13;         // dividend bits
    localparam int RB = FB + 1;          // square root bits
    localparam int SW = 2 * FB + 3;      // square sum bits
    localparam int CW = FB + 4;          // cordic datapath
    localparam int NSTG = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int CLAT = NSTG + 1;
    localparam int PB = ANG_W - 1;
    localparam int MW = PB + CFG_W + 1;
    localparam logic signed [DW-1:0] ONE = {2'b01, {FB{1'b0}}};

    logic [CFG_W-2:0] h;
    logic [CFG_W-3:0] f;

    assign h = i_w[CFG_W-1:1];
    assign f = i_w[CFG_W-1:2];

    // entry register, dividends for the pixel centre mapping
    logic          r_a_vld, r_a_bad;
    logic [NB-1:0] r_a_nu, r_a_nv;
    logic [2:0]    r_a_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
        r_a_bad <= i_entry.bad;
        r_a_face <= i_entry.face;
        r_a_nu <= (NB'({i_entry.px, 1'b1}) << FB) + NB'(f >> 1);
        r_a_nv <= (NB'({i_entry.py, 1'b1}) << FB) + NB'(f >> 1);
    end

    // restoring divide by the face size, one quotient bit a stage
    logic          r_dv_vld   [QB];
    logic          r_dv_bad   [QB];
    logic [2:0]    r_dv_face  [QB];
    logic [NB-1:0] r_dv_rem_u [QB];
    logic [NB-1:0] r_dv_rem_v [QB];
    logic [QB-1:0] r_dv_q_u   [QB];
    logic [QB-1:0] r_dv_q_v   [QB];

    for (genvar s = 0; s < QB; s++) begin : g_div
        localparam int K = QB - 1 - s;
        logic          vld_in, bad_in;
        logic [2:0]    face_in;
        logic [NB-1:0] ru_in, rv_in, dsh;
        logic [QB-1:0] qu_in, qv_in;

        if (s == 0) begin : g_first
            assign vld_in = r_a_vld;
            assign bad_in = r_a_bad;
            assign face_in = r_a_face;
            assign ru_in = r_a_nu;
            assign rv_in = r_a_nv;
            assign qu_in = '0;
            assign qv_in = '0;
        end else begin : g_next
            assign vld_in = r_dv_vld[s-1];
            assign bad_in = r_dv_bad[s-1];
            assign face_in = r_dv_face[s-1];
            assign ru_in = r_dv_rem_u[s-1];
            assign rv_in = r_dv_rem_v[s-1];
            assign qu_in = r_dv_q_u[s-1];
            assign qv_in = r_dv_q_v[s-1];
        end

        assign dsh = NB'(f) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s] <= 1'b0;
            end else begin
                r_dv_vld[s] <= vld_in;
            end
            r_dv_bad[s] <= bad_in;
            r_dv_face[s] <= face_in;
            if (ru_in >= dsh) begin
                r_dv_rem_u[s] <= ru_in - dsh;
                r_dv_q_u[s] <= qu_in | (QB'(1) << K);
            end else begin
                r_dv_rem_u[s] <= ru_in;
                r_dv_q_u[s] <= qu_in;
            end
            if (rv_in >= dsh) begin
                r_dv_rem_v[s] <= rv_in - dsh;
                r_dv_q_v[s] <= qv_in | (QB'(1) << K);
            end else begin
                r_dv_rem_v[s] <= rv_in;
                r_dv_q_v[s] <= qv_in;
            end
        end
    end

    // face orientation
    logic signed [DW-1:0] u_c, v_c, dx_c, dy_c, dz_c;
    logic                 r_f_vld, r_f_bad;
    logic signed [DW-1:0] r_f_dx, r_f_dy, r_f_dz;

    assign u_c = $signed({1'b0, r_dv_q_u[QB-1]}) - ONE;
    assign v_c = $signed({1'b0, r_dv_q_v[QB-1]}) - ONE;

    always_comb begin
        dx_c = '0;
        dy_c = '0;
        dz_c = '0;
        unique case (r_dv_face[QB-1])
            FACE_POS_X: begin
                dx_c = ONE;  dy_c = -v_c; dz_c = -u_c;
            end
            FACE_NEG_X: begin
                dx_c = -ONE; dy_c = -v_c; dz_c = u_c;
            end
            FACE_POS_Y: begin
                dx_c = u_c;  dy_c = ONE;  dz_c = v_c;
            end
            FACE_NEG_Y: begin
                dx_c = u_c;  dy_c = -ONE; dz_c = -v_c;
            end
            FACE_POS_Z: begin
                dx_c = u_c;  dy_c = -v_c; dz_c = ONE;
            end
            FACE_NEG_Z: begin
                dx_c = -u_c; dy_c = -v_c; dz_c = -ONE;
            end
            default: begin
                // invalid face leaves the zero vector
                dx_c = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_dv_vld[QB-1];
        end
        r_f_bad <= r_dv_bad[QB-1];
        r_f_dx <= dx_c;
        r_f_dy <= dy_c;
        r_f_dz <= dz_c;
    end

    // squares, then their sum
    logic signed [2*DW-1:0] prod_x, prod_z;
    logic                   r_s_vld, r_s_bad;
    logic [SW-1:0]          r_s_xx, r_s_zz;
    logic signed [DW-1:0]   r_s_dx, r_s_dy, r_s_dz;
    logic                   r_m_vld, r_m_bad;
    logic [SW-1:0]          r_m_sum;
    logic signed [DW-1:0]   r_m_dx, r_m_dy, r_m_dz;

    assign prod_x = r_f_dx * r_f_dx;
    assign prod_z = r_f_dz * r_f_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_m_vld <= 1'b0;
        end else begin
            r_s_vld <= r_f_vld;
            r_m_vld <= r_s_vld;
        end
        r_s_bad <= r_f_bad;
        r_s_xx <= SW'($unsigned(prod_x));
        r_s_zz <= SW'($unsigned(prod_z));
        r_s_dx <= r_f_dx;
        r_s_dy <= r_f_dy;
        r_s_dz <= r_f_dz;
        r_m_bad <= r_s_bad;
        r_m_sum <= r_s_xx + r_s_zz;
        r_m_dx <= r_s_dx;
        r_m_dy <= r_s_dy;
        r_m_dz <= r_s_dz;
    end

    // integer square root, one result bit a stage, remainder kept as n - res^2
    logic                 r_q_vld [RB];
    logic                 r_q_bad [RB];
    logic [SW-1:0]        r_q_rem [RB];
    logic [RB-1:0]        r_q_res [RB];
    logic signed [DW-1:0] r_q_dx  [RB];
    logic signed [DW-1:0] r_q_dy  [RB];
    logic signed [DW-1:0] r_q_dz  [RB];

    for (genvar t = 0; t < RB; t++) begin : g_sqrt
        localparam int B = RB - 1 - t;
        logic                 vld_in, bad_in;
        logic [SW-1:0]        rem_in, trial;
        logic [RB-1:0]        res_in;
        logic signed [DW-1:0] dx_in, dy_in, dz_in;

        if (t == 0) begin : g_first
            assign vld_in = r_m_vld;
            assign bad_in = r_m_bad;
            assign rem_in = r_m_sum;
            assign res_in = '0;
            assign dx_in = r_m_dx;
            assign dy_in = r_m_dy;
            assign dz_in = r_m_dz;
        end else begin : g_next
            assign vld_in = r_q_vld[t-1];
            assign bad_in = r_q_bad[t-1];
            assign rem_in = r_q_rem[t-1];
            assign res_in = r_q_res[t-1];
            assign dx_in = r_q_dx[t-1];
            assign dy_in = r_q_dy[t-1];
            assign dz_in = r_q_dz[t-1];
        end

        assign trial = (SW'(res_in) << (B + 1)) + (SW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[t] <= 1'b0;
            end else begin
                r_q_vld[t] <= vld_in;
            end
            r_q_bad[t] <= bad_in;
            r_q_dx[t] <= dx_in;
            r_q_dy[t] <= dy_in;
            r_q_dz[t] <= dz_in;
            if (rem_in >= trial) begin
                r_q_rem[t] <= rem_in - trial;
                r_q_res[t] <= res_in | (RB'(1) << B);
            end else begin
                r_q_rem[t] <= rem_in;
                r_q_res[t] <= res_in;
            end
        end
    end

    // longitude and latitude side by side
    logic signed [CW-1:0]    phi_x, phi_y, th_x, th_y;
    logic                    phi_vld, th_vld;
    logic signed [ANG_W-1:0] phi, theta;

    assign phi_x = {{(CW-DW){r_q_dx[RB-1][DW-1]}}, r_q_dx[RB-1]};
    assign phi_y = {{(CW-DW){r_q_dz[RB-1][DW-1]}}, r_q_dz[RB-1]};
    assign th_x = {{(CW-RB){1'b0}}, r_q_res[RB-1]};
    assign th_y = -{{(CW-DW){r_q_dy[RB-1][DW-1]}}, r_q_dy[RB-1]};

    e2c_cordic #(.CW(CW), .STAGES(NSTG)) u_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q_vld[RB-1]),
        .i_x     (phi_x),
        .i_y     (phi_y),
        .o_valid (phi_vld),
        .o_ang   (phi)
    );

    e2c_cordic #(.CW(CW), .STAGES(NSTG)) u_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_q_vld[RB-1]),
        .i_x     (th_x),
        .i_y     (th_y),
        .o_valid (th_vld),
        .o_ang   (theta)
    );

    logic r_bd_bad [CLAT];

    for (genvar d = 0; d < CLAT; d++) begin : g_bad_dly
        if (d == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_bd_bad[d] <= r_q_bad[RB-1];
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_bd_bad[d] <= r_bd_bad[d-1];
            end
        end
    end

    // angles to source coordinates
    logic signed [ANG_W-1:0] p_s, t_s;
    logic                    r_p1_vld, r_p1_bad;
    logic [PB-1:0]           r_p1_p, r_p1_t;
    logic                    r_p2_vld, r_p2_bad;
    logic [MW-2:0]           r_p2_pw;
    logic [MW-3:0]           r_p2_th;

    assign p_s = phi + ANG_HALF;
    assign t_s = ANG_QUARTER - theta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= phi_vld && th_vld;
            r_p2_vld <= r_p1_vld;
        end
        r_p1_bad <= r_bd_bad[CLAT-1];
        r_p1_p <= p_s[ANG_W-1] ? '0 : p_s[PB-1:0];
        r_p1_t <= t_s[ANG_W-1] ? '0 : t_s[PB-1:0];
        r_p2_bad <= r_p1_bad;
        r_p2_pw <= (MW-1)'(r_p1_p) * (MW-1)'(i_w);
        r_p2_th <= (MW-2)'(r_p1_t) * (MW-2)'(h);
    end

    // round, clamp, flip the row
    logic [MW-1:0]    col_sum;
    logic [MW-2:0]    row_sum;
    logic [15:0]      col_raw, r0_raw;
    logic [CFG_W-1:0] w_m1, col_c;
    logic [CFG_W-2:0] h_m1, r0_c, row_c;
    logic             r_p3_vld, r_p3_bad;
    logic [CFG_W-1:0] r_p3_col;
    logic [CFG_W-2:0] r_p3_row;

    assign col_sum = MW'(r_p2_pw) + (MW'(1) << (ANG_FRAC - 1));
    assign row_sum = (MW-1)'(r_p2_th) + ((MW-1)'(1) << (ANG_FRAC - 2));
    assign col_raw = 16'(col_sum >> ANG_FRAC);
    assign r0_raw = 16'(row_sum >> (ANG_FRAC - 1));
    assign w_m1 = i_w - CFG_W'(1);
    assign h_m1 = h - (CFG_W-1)'(1);
    assign col_c = (col_raw > 16'(w_m1)) ? w_m1 : col_raw[CFG_W-1:0];
    assign r0_c = (r0_raw > 16'(h_m1)) ? h_m1 : r0_raw[CFG_W-2:0];
    assign row_c = h_m1 - r0_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld;
        end
        r_p3_bad <= r_p2_bad;
        r_p3_col <= col_c;
        r_p3_row <= row_c;
    end

    // linear index and result register
    localparam int IW = 2 * CFG_W - 1;
    logic [IW-1:0] idx_c;
    logic          r_strobe;
    t_res          r_out;

    assign idx_c = IW'(r_p3_row) * IW'(i_w) + IW'(r_p3_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_p3_vld;
        end
        r_out.src_col <= r_p3_col[12:0];
        r_out.src_row <= r_p3_row[11:0];
        r_out.src_index <= idx_c[24:0];
        r_out.face_bad <= r_p3_bad;
    end

    assign o_strobe = r_strobe;
    assign o_res = r_out;

endmodule

[design/equirect_to_cubemap_addr.sv]
`timescale 1ns / 1ps
`include "equirect_to_cubemap_addr_assert.svh"
// channel   direction  handshake                  payload
// item      in         start high, busy low       i_item (face, pix_x, pix_y)
// result    out        o_strobe, one cycle        o_res (src_col, src_row, src_index, face_bad)
// config    in         i_cfg_valid, o_cfg_ready   i_cfg_data (src_width)
//
// one item a cycle while busy is low; the datapath is fully pipelined, the strobe rises
// as the item's result is registered, after the queue and every stage of the pipeline
// (divider and square root one bit a stage, cordic one rotation a stage)
// the front clamps and classifies into a two-beat queue, busy is queue full
// synchronous active-low reset clears control state; src_width resets to 2048
// the receiver cannot stall: each result shows for exactly one cycle
module equirect_to_cubemap_addr import e2c_pkg::*; #(
    parameter int MAX_SRC_WIDTH = 8192,
    parameter int FRAC_BITS = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_strobe,
    output t_res             o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_w, n_w;

    assign o_cfg_ready = 1'b1;

    // stored width is already clamped to the legal range
    always_comb begin
        n_w = r_w;
        if (i_cfg_valid && o_cfg_ready) begin
            priority if (i_cfg_data < SRC_W_MIN) begin
                n_w = SRC_W_MIN;
            end else if ({1'b0, i_cfg_data} > (CFG_W+1)'(MAX_SRC_WIDTH)) begin
                n_w = CFG_W'(MAX_SRC_WIDTH);
            end else begin
                n_w = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= SRC_W_RESET;
        end else begin
            r_w <= n_w;
        end
    end

    t_push  push;
    logic   q_full, q_valid;
    t_entry q_entry;

    e2c_front u_front (
        .i_start     (start),
        .i_item      (i_item),
        .i_face_size (r_w[CFG_W-1:2]),
        .i_full      (q_full),
        .o_busy      (busy),
        .o_push      (push)
    );

    e2c_queue #(.DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_valid),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    e2c_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .i_w      (r_w),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    logic [CFG_W-1:0] a_col, a_row, a_h;
    logic [12:0]      a_mid_col;
    logic             a_bad_strobe;

    assign a_col = CFG_W'(o_res.src_col);
    assign a_row = CFG_W'(o_res.src_row);
    assign a_h = r_w >> 1;
    assign a_mid_col = 13'(((CFG_W+1)'(r_w) + (CFG_W+1)'(1)) >> 1);
    assign a_bad_strobe = o_strobe && o_res.face_bad;

    `E2C_ASSERT_IMP(a_col_in_range, i_clk, i_rst_n, o_strobe, a_col < r_w, "column past width")
    `E2C_ASSERT_NEVER(a_row_in_range, i_clk, i_rst_n, o_strobe && (a_row >= a_h), "row past height")
    `E2C_ASSERT_IMP(a_bad_face_mid, i_clk, i_rst_n, a_bad_strobe, o_res.src_col == a_mid_col, "bad face")
    `E2C_ASSERT_IMP(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_strobe, "strobe after reset")

endmodule
